// File: src/cff_dict_token_decoder_assert.svh
// Assertion macros for the CFF DICT token decoder, active outside synthesis only.
`ifndef CFF_DICT_TOKEN_DECODER_ASSERT_SVH
`define CFF_DICT_TOKEN_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define CDTD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cdtd assertion failed");
// Implication checked on the same edge as its trigger.
`define CDTD_ASSERT_IMP(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("cdtd implication failed");
`else
`define CDTD_ASSERT(label, prop)
`define CDTD_ASSERT_IMP(label, trig, cons)
`endif
`endif

// File: src/cdtd_pkg.sv
// Shared types, codes and helper functions of the CFF DICT token decoder.
package cdtd_pkg;

    // Token kinds carried on the result channel.
    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_OP   = 2'd1;
    localparam logic [1:0] KIND_ESC  = 2'd2;
    localparam logic [1:0] KIND_REAL = 2'd3;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Lead byte codes of the DICT encoding.
    localparam logic [7:0] BYTE_ESCAPE = 8'd12;
    localparam logic [7:0] BYTE_OP_MAX = 8'd21;
    localparam logic [7:0] BYTE_SHORT  = 8'd28;
    localparam logic [7:0] BYTE_LONG   = 8'd29;
    localparam logic [7:0] BYTE_REAL   = 8'd30;
    localparam logic [7:0] BYTE_INT1_LO = 8'd32;
    localparam logic [7:0] BYTE_INT1_HI = 8'd246;
    localparam logic [7:0] BYTE_POS_LO  = 8'd247;
    localparam logic [7:0] BYTE_POS_HI  = 8'd250;
    localparam logic [7:0] BYTE_NEG_LO  = 8'd251;
    localparam logic [7:0] BYTE_NEG_HI  = 8'd254;

    // Nibble codes inside a real number.
    localparam logic [3:0] NIB_POINT = 4'h0a;
    localparam logic [3:0] NIB_EXP   = 4'h0b;
    localparam logic [3:0] NIB_EXPN  = 4'h0c;
    localparam logic [3:0] NIB_RES   = 4'h0d;
    localparam logic [3:0] NIB_MINUS = 4'h0e;
    localparam logic [3:0] NIB_END   = 4'h0f;

    // Parser modes, one-hot.
    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_ESC  = 6'b000010,
        MODE_POS2 = 6'b000100,
        MODE_NEG2 = 6'b001000,
        MODE_WIDE = 6'b010000,
        MODE_REAL = 6'b100000
    } cdtd_mode_t;

    // All results caused by one input byte.
    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       int_value;
        logic [7:0]        op_code;
        logic [3:0][6:0]   chars;
        logic [2:0]        count;
        logic              done;
    } cdtd_entry_t;

    // Queue fill status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } cdtd_q_status_t;

    // Number of characters that one real-number nibble yields.
    function automatic logic [1:0] nib_count(input logic [3:0] nib);
        logic [1:0] res;
        begin
            res = 2'd1;
            if (nib inside {NIB_END, NIB_RES})
                res = 2'd0;
            else if (nib == NIB_EXPN)
                res = 2'd2;
            return res;
        end
    endfunction

    // ASCII character number sel of a real-number nibble.
    function automatic logic [6:0] nib_char(input logic [3:0] nib, input logic sel);
        logic [6:0] res;
        begin
            res = 7'd0;
            if (nib <= 4'd9)
                res = 7'h30 + {3'b000, nib};
            else if (nib == NIB_POINT)
                res = 7'h2e;
            else if (nib == NIB_EXP)
                res = 7'h45;
            else if (nib == NIB_EXPN)
                res = sel ? 7'h2d : 7'h45;
            else if (nib == NIB_MINUS)
                res = 7'h2d;
            return res;
        end
    endfunction

endpackage

// File: src/cdtd_front.sv
// Front end: accepts DICT bytes, tracks the token parse and builds at most one entry per byte.
module cdtd_front
    import cdtd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    output logic        push,
    output cdtd_entry_t push_entry
);

    cdtd_mode_t  mode_reg, mode_next;
    logic [2:0]  pending_reg, pending_next;
    logic [7:0]  lead_reg, lead_next;
    logic [31:0] gathered_reg, gathered_next;

    logic [10:0] pos_val, neg_val;
    logic [31:0] wide_val;
    logic [3:0]  hi_nib, lo_nib;
    logic        hi_end, lo_end, real_end;
    logic [1:0]  cnt_hi, cnt_lo;
    logic [2:0]  real_total;
    logic [3:0][6:0] real_chars;

    // Two-byte operand magnitudes: (lead - base) * 256 + byte + 108.
    assign pos_val = ((11'(lead_reg) - 11'(BYTE_POS_LO)) << 8) + 11'(data_byte) + 11'd108;
    assign neg_val = ((11'(lead_reg) - 11'(BYTE_NEG_LO)) << 8) + 11'(data_byte) + 11'd108;

    // Wide operand once the last byte is in; code 28 is sign-extended from 16 bits.
    always_comb
    begin
        wide_val = {gathered_reg[23:0], data_byte};
        if (lead_reg == BYTE_SHORT)
            wide_val = {{16{gathered_reg[7]}}, gathered_reg[7:0], data_byte};
    end

    // Characters of a real-number byte: high nibble first, low nibble unless the high one ends.
    assign hi_nib   = data_byte[7:4];
    assign lo_nib   = data_byte[3:0];
    assign hi_end   = (hi_nib == NIB_END);
    assign lo_end   = !hi_end && (lo_nib == NIB_END);
    assign real_end = hi_end || lo_end;
    assign cnt_hi   = nib_count(hi_nib);
    assign cnt_lo   = hi_end ? 2'd0 : nib_count(lo_nib);

    always_comb
    begin
        logic [2:0] rel;
        real_chars = '0;
        for (int i = 0; i < 4; i++)
        begin
            rel = 3'(i) - {1'b0, cnt_hi};
            if (3'(i) < {1'b0, cnt_hi})
                real_chars[i] = nib_char(hi_nib, i[0]);
            else if (rel < {1'b0, cnt_lo})
                real_chars[i] = nib_char(lo_nib, rel[0]);
        end
        real_total = {1'b0, cnt_hi} + {1'b0, cnt_lo};
        // An end with no character still carries one empty result.
        if (real_end && real_total == 3'd0)
            real_total = 3'd1;
    end

    // Parse state transitions and entry build.
    always_comb
    begin
        mode_next     = mode_reg;
        pending_next  = pending_reg;
        lead_next     = lead_reg;
        gathered_next = gathered_reg;
        push          = 1'b0;
        push_entry    = '0;
        if (accept)
        begin
            case (mode_reg)
                MODE_ESC:
                begin
                    push_entry.kind    = KIND_ESC;
                    push_entry.op_code = data_byte;
                    push_entry.count   = 3'd1;
                    push               = 1'b1;
                    mode_next          = MODE_IDLE;
                end
                MODE_POS2:
                begin
                    push_entry.kind      = KIND_INT;
                    push_entry.int_value = 32'(pos_val);
                    push_entry.count     = 3'd1;
                    push                 = 1'b1;
                    mode_next            = MODE_IDLE;
                end
                MODE_NEG2:
                begin
                    push_entry.kind      = KIND_INT;
                    push_entry.int_value = 32'd0 - 32'(neg_val);
                    push_entry.count     = 3'd1;
                    push                 = 1'b1;
                    mode_next            = MODE_IDLE;
                end
                MODE_WIDE:
                begin
                    gathered_next = {gathered_reg[23:0], data_byte};
                    pending_next  = pending_reg - 3'd1;
                    if (pending_reg == 3'd1)
                    begin
                        push_entry.kind      = KIND_INT;
                        push_entry.int_value = wide_val;
                        push_entry.count     = 3'd1;
                        push                 = 1'b1;
                        mode_next            = MODE_IDLE;
                    end
                end
                MODE_REAL:
                begin
                    push_entry.kind  = KIND_REAL;
                    push_entry.chars = real_chars;
                    push_entry.count = real_total;
                    push_entry.done  = real_end;
                    push             = (real_total != 3'd0);
                    if (real_end)
                        mode_next = MODE_IDLE;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    lead_next = data_byte;
                    if (data_byte == BYTE_ESCAPE)
                        mode_next = MODE_ESC;
                    else if (data_byte <= BYTE_OP_MAX)
                    begin
                        push_entry.kind    = KIND_OP;
                        push_entry.op_code = data_byte;
                        push_entry.count   = 3'd1;
                        push               = 1'b1;
                    end
                    else if (data_byte == BYTE_REAL)
                        mode_next = MODE_REAL;
                    else if (data_byte inside {[BYTE_INT1_LO:BYTE_INT1_HI]})
                    begin
                        push_entry.kind      = KIND_INT;
                        push_entry.int_value = 32'(data_byte) - 32'd139;
                        push_entry.count     = 3'd1;
                        push                 = 1'b1;
                    end
                    else if (data_byte inside {[BYTE_POS_LO:BYTE_POS_HI]})
                        mode_next = MODE_POS2;
                    else if (data_byte inside {[BYTE_NEG_LO:BYTE_NEG_HI]})
                        mode_next = MODE_NEG2;
                    else if (data_byte inside {BYTE_SHORT, BYTE_LONG})
                    begin
                        mode_next     = MODE_WIDE;
                        gathered_next = '0;
                        pending_next  = (data_byte == BYTE_SHORT) ? 3'd2 : 3'd4;
                    end
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            pending_reg  <= '0;
            lead_reg     <= '0;
            gathered_reg <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            pending_reg  <= pending_next;
            lead_reg     <= lead_next;
            gathered_reg <= gathered_next;
        end
    end

endmodule

// File: src/cdtd_queue.sv
// Short register queue of byte entries between the front end and the back end.
module cdtd_queue
    import cdtd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cdtd_entry_t    push_entry,
    input  logic           pop,
    output cdtd_entry_t    pop_entry,
    output cdtd_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cdtd_entry_t       slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_entry    = slots_reg[rd_ptr_reg];

    // Pointer and fill count update, with explicit wrap.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: src/cdtd_back.sv
// Back end: expands each queued entry into its results and holds them in the output register.
module cdtd_back
    import cdtd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cdtd_q_status_t     q_status,
    input  cdtd_entry_t        q_entry,
    output logic               pop,
    output logic               token_valid,
    input  logic               token_stall,
    output logic [1:0]         token_kind,
    output logic signed [31:0] int_value,
    output logic [7:0]         op_code,
    output logic [6:0]         real_char,
    output logic               real_done,
    output logic               last_of_run
);

    cdtd_entry_t        cur_reg;
    logic               cur_valid_reg, cur_valid_next;
    logic [1:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg;
    logic signed [31:0] value_reg;
    logic [7:0]         op_reg;
    logic [6:0]         char_reg;
    logic               done_reg, last_reg;
    logic               load_out, cur_last;

    // The output register takes a result from the current entry whenever it is empty or being drained.
    assign load_out = cur_valid_reg && (!out_valid_reg || !token_stall);
    assign cur_last = ({1'b0, idx_reg} == (cur_reg.count - 3'd1));
    assign pop      = !q_status.empty && (!cur_valid_reg || (load_out && cur_last));

    // Current entry and result index.
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            idx_next = idx_reg + 2'd1;
            if (cur_last)
                cur_valid_next = 1'b0;
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        if (load_out)
            out_valid_next = 1'b1;
        else if (!token_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the current entry and of the output.
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_entry;
        if (load_out)
        begin
            kind_reg  <= cur_reg.kind;
            value_reg <= cur_reg.int_value;
            op_reg    <= cur_reg.op_code;
            char_reg  <= cur_reg.chars[idx_reg];
            done_reg  <= cur_reg.done;
            last_reg  <= cur_last;
        end
    end

    assign token_valid = out_valid_reg;
    assign token_kind  = kind_reg;
    assign int_value   = value_reg;
    assign op_code     = op_reg;
    assign real_char   = char_reg;
    assign real_done   = done_reg;
    assign last_of_run = last_reg;

endmodule

// File: src/cff_dict_token_decoder.sv
// Top level of the CFF DICT token decoder: front end, entry queue and back end.
//
// Input channel: data_valid / data_stall carry one DICT byte (data_byte) per
// transfer. Output channel: token_valid / token_stall carry one decoded token
// per transfer: kind, integer value, operator code, real-number character and
// the real_done and last_of_run marks.
// A byte is parsed in the cycle it is transferred; the bytes that produce
// results leave one entry in a queue of DEPTH entries. The back end expands
// each entry into one to four results, one per cycle while token_stall is low.
// When the block is empty, the first result of a byte passes the queue slot,
// the current-entry register and the output register. Throughput: one input
// byte per cycle while the queue has room, one result per cycle while token_stall
// is low; each real-number character is a result, so the output rate sets sustained intake.
// data_stall is high while the queue is full. When token_stall is high the
// output register holds its token and the back end waits; the front end keeps
// taking bytes until the queue fills.
// Reset clears the parse state to idle, empties the queue and the output.
`include "cff_dict_token_decoder_assert.svh"

module cff_dict_token_decoder
    import cdtd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               data_valid,
    output logic               data_stall,
    input  logic [7:0]         data_byte,
    output logic               token_valid,
    input  logic               token_stall,
    output logic [1:0]         token_kind,
    output logic signed [31:0] int_value,
    output logic [7:0]         op_code,
    output logic [6:0]         real_char,
    output logic               real_done,
    output logic               last_of_run
);

    cdtd_q_status_t q_status;
    cdtd_entry_t    push_entry, pop_entry;
    logic           push, pop, accept;

    assign data_stall = q_status.full;
    assign accept     = data_valid && !data_stall;

    cdtd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    cdtd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    cdtd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_entry     (pop_entry),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_kind  (token_kind),
        .int_value   (int_value),
        .op_code     (op_code),
        .real_char   (real_char),
        .real_done   (real_done),
        .last_of_run (last_of_run)
    );

    // The end of a real number is only ever marked on real-number characters.
    `CDTD_ASSERT_IMP(a_done_is_real, token_valid && real_done, token_kind == KIND_REAL)
    // Integer values appear only on integer tokens.
    `CDTD_ASSERT_IMP(a_value_int_only, token_valid && token_kind != KIND_INT, int_value == 32'sd0)
    // Characters appear only on real-number tokens.
    `CDTD_ASSERT_IMP(a_char_real_only, token_valid && token_kind != KIND_REAL, real_char == 7'd0)
    // The queue is never reported full and empty together.
    `CDTD_ASSERT(a_queue_status, !(q_status.full && q_status.empty))

endmodule
